>>> rtl/ubd_pkg.sv
`default_nettype none

package ubd_pkg;

    // Sample width of the ADC; every sample-wide signal follows from it.
    localparam int SAMPLE_BITS = 12;

    localparam int BASE_W  = 12;
    localparam int DEV_W   = (SAMPLE_BITS > BASE_W) ? SAMPLE_BITS : BASE_W;
    localparam int PEAK_W  = 12;
    localparam int CNT_W   = 16;
    localparam int TIME_W  = 32;
    localparam int PCT_W   = 7;
    localparam int DIV_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

    localparam logic [PCT_W-1:0] PCT_MIN  = 7'd10;
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [6:0]  PCT_SPAN  = 7'd90;
    localparam logic [12:0] FREQ_SCALE = 13'd5000;

    localparam logic [BASE_W-1:0] RST_BASELINE = 12'd2048;
    localparam logic [BASE_W-1:0] RST_THRESH   = 12'd120;
    localparam logic [15:0]       RST_MIN_US   = 16'd500;
    localparam logic [15:0]       RST_MAX_US   = 16'd5000;
    localparam logic [BASE_W-1:0] RST_FULL     = 12'd800;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASELINE = 3'd0,
        CFG_THRESH   = 3'd1,
        CFG_MIN_US   = 3'd2,
        CFG_MAX_US   = 3'd3,
        CFG_FULL     = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_LONG  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_STR,
        S_STR_WAIT,
        S_FRQ,
        S_FRQ_WAIT,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/ubd_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ubd_div
    import ubd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quotient
);

    localparam int CNT_BITS = $clog2(DIV_W);

    logic [DIV_W-1:0]    r_q;
    logic [DIV_W-1:0]    r_rem;
    logic [DIV_W-1:0]    r_div;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [DIV_W:0] rem_sh;
    logic           ge;
    logic [DIV_W:0] rem_sub;

    assign rem_sh  = {r_rem, r_q[DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-2:0], ge};
            r_rem <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

>>> rtl/ultrasonic_burst_detector.sv
`default_nettype none

// Ultrasonic burst detector with a zero-crossing frequency estimate.
// Input channel: i_in_valid / o_in_stall carry one ADC sample and its
// microsecond timestamp per transfer. Output channel: o_out_valid /
// i_out_stall carry one burst report per transfer. The configuration
// channel (i_cfg_valid / o_cfg_ready) is always ready; indexes beyond the
// register list are ignored. Write it only while no burst report is pending.
// A sample that causes no report holds o_in_stall high only while it is evaluated.
// A rejected burst (too short or too long) passes from S_EVAL through S_STR
// to S_OUT, where it is loaded into the output register. An accepted burst runs
// up to two divisions on the shared divider, strength and then frequency;
// the strength needs none when it is set to its lowest or full value, and the
// frequency needs none when the duration is zero.
// The report sits in an output register, so a stalled receiver does not hold
// up sample processing until a second report is ready to be loaded.
// Synchronous reset restores the register defaults, leaves the detector
// idle and empties the output register.
module ultrasonic_burst_detector
    import ubd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [TIME_W-1:0]      i_time_us,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [1:0]                  o_status,
    output logic [CNT_W-1:0]            o_duration_us,
    output logic [CNT_W-1:0]            o_crossing_count,
    output logic [PEAK_W-1:0]           o_peak_deviation,
    output logic [PCT_W-1:0]            o_strength_pct,
    output logic [CNT_W-1:0]            o_freq_tenths_khz,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // Configuration registers
    logic [BASE_W-1:0] r_baseline;
    logic [BASE_W-1:0] r_thresh;
    logic [15:0]       r_min_us;
    logic [15:0]       r_max_us;
    logic [BASE_W-1:0] r_full;

    t_state r_state, n_state;

    logic [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic [TIME_W-1:0]      r_time, n_time;

    logic              r_in_burst, n_in_burst;
    logic [TIME_W-1:0] r_start, n_start;
    logic [PEAK_W-1:0] r_peak, n_peak;
    logic [CNT_W-1:0]  r_cross, n_cross;
    logic              r_last, n_last;

    logic [TIME_W-1:0] r_elapsed, n_elapsed;
    t_status           r_status, n_status;
    logic [PCT_W-1:0]  r_str, n_str;
    logic [CNT_W-1:0]  r_freq, n_freq;

    logic              r_o_valid, n_o_valid;
    t_status           r_o_status, n_o_status;
    logic [CNT_W-1:0]  r_o_dur, n_o_dur;
    logic [CNT_W-1:0]  r_o_cross, n_o_cross;
    logic [PEAK_W-1:0] r_o_peak, n_o_peak;
    logic [PCT_W-1:0]  r_o_str, n_o_str;
    logic [CNT_W-1:0]  r_o_freq, n_o_freq;

    logic             div_start;
    logic [DIV_W-1:0] div_num;
    logic [DIV_W-1:0] div_den;
    logic             div_busy;
    logic             div_done;
    logic [DIV_W-1:0] div_q;

    logic [DEV_W-1:0]  sample_ext;
    logic [DEV_W-1:0]  base_ext;
    logic [DEV_W-1:0]  dev;
    logic [PEAK_W-1:0] dev_sat;
    logic              above;
    logic              ended;
    logic [TIME_W-1:0] elapsed;
    logic [18:0]       str_num;
    logic [28:0]       frq_num;

    assign sample_ext = DEV_W'(r_sample);
    assign base_ext   = DEV_W'(r_baseline);
    assign above      = sample_ext > base_ext;
    assign dev        = above ? (sample_ext - base_ext) : (base_ext - sample_ext);
    assign dev_sat    = (dev > DEV_W'(PEAK_MAX)) ? PEAK_MAX : dev[PEAK_W-1:0];
    assign ended      = dev < DEV_W'(r_thresh >> 1);
    assign elapsed    = r_time - r_start;
    assign str_num    = 19'(r_peak - r_thresh) * 19'(PCT_SPAN);
    assign frq_num    = 29'(r_cross) * 29'(FREQ_SCALE);

    ubd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline <= RST_BASELINE;
            r_thresh   <= RST_THRESH;
            r_min_us   <= RST_MIN_US;
            r_max_us   <= RST_MAX_US;
            r_full     <= RST_FULL;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BASELINE: r_baseline <= i_cfg_data[BASE_W-1:0];
                CFG_THRESH:   r_thresh   <= i_cfg_data[BASE_W-1:0];
                CFG_MIN_US:   r_min_us   <= i_cfg_data;
                CFG_MAX_US:   r_max_us   <= i_cfg_data;
                CFG_FULL:     r_full     <= i_cfg_data[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_burst <= 1'b0;
            r_start    <= '0;
            r_peak     <= '0;
            r_cross    <= '0;
            r_last     <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_burst <= n_in_burst;
            r_start    <= n_start;
            r_peak     <= n_peak;
            r_cross    <= n_cross;
            r_last     <= n_last;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_time     <= n_time;
        r_elapsed  <= n_elapsed;
        r_status   <= n_status;
        r_str      <= n_str;
        r_freq     <= n_freq;
        r_o_status <= n_o_status;
        r_o_dur    <= n_o_dur;
        r_o_cross  <= n_o_cross;
        r_o_peak   <= n_o_peak;
        r_o_str    <= n_o_str;
        r_o_freq   <= n_o_freq;
    end

    always_comb begin
        n_state    = r_state;
        n_sample   = r_sample;
        n_time     = r_time;
        n_in_burst = r_in_burst;
        n_start    = r_start;
        n_peak     = r_peak;
        n_cross    = r_cross;
        n_last     = r_last;
        n_elapsed  = r_elapsed;
        n_status   = r_status;
        n_str      = r_str;
        n_freq     = r_freq;
        // A waiting report leaves the output register when it is taken.
        n_o_valid  = r_o_valid & i_out_stall;
        n_o_status = r_o_status;
        n_o_dur    = r_o_dur;
        n_o_cross  = r_o_cross;
        n_o_peak   = r_o_peak;
        n_o_str    = r_o_str;
        n_o_freq   = r_o_freq;
        div_start  = 1'b0;
        div_num    = DIV_W'(str_num);
        div_den    = DIV_W'(r_full - r_thresh);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sample = i_sample;
                    n_time   = i_time_us;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                if (!r_in_burst) begin
                    if (dev >= DEV_W'(r_thresh)) begin
                        n_in_burst = 1'b1;
                        n_start    = r_time;
                        n_peak     = dev_sat;
                        n_cross    = '0;
                        n_last     = above;
                    end
                end else begin
                    if (above != r_last && r_cross != CNT_MAX) begin
                        n_cross = r_cross + 1'b1;
                    end
                    n_last = above;
                    if (dev_sat > r_peak) begin
                        n_peak = dev_sat;
                    end
                    n_elapsed = elapsed;
                    if (ended || elapsed > TIME_W'(r_max_us)) begin
                        n_in_burst = 1'b0;
                        if (elapsed > TIME_W'(r_max_us)) begin
                            n_status = ST_LONG;
                        end else if (elapsed < TIME_W'(r_min_us)) begin
                            n_status = ST_SHORT;
                        end else begin
                            n_status = ST_OK;
                        end
                        n_state = S_STR;
                    end
                end
            end
            S_STR: begin
                if (r_status != ST_OK) begin
                    n_str   = '0;
                    n_freq  = '0;
                    n_state = S_OUT;
                end else if (r_full <= r_thresh) begin
                    n_str   = PCT_FULL;
                    n_state = S_FRQ;
                end else if (r_peak <= r_thresh) begin
                    n_str   = PCT_MIN;
                    n_state = S_FRQ;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_STR_WAIT;
                end
            end
            S_STR_WAIT: begin
                if (div_done) begin
                    if (div_q > DIV_W'(PCT_SPAN)) begin
                        n_str = PCT_FULL;
                    end else begin
                        n_str = div_q[PCT_W-1:0] + PCT_MIN;
                    end
                    n_state = S_FRQ;
                end
            end
            S_FRQ: begin
                if (r_elapsed == '0) begin
                    n_freq  = '0;
                    n_state = S_OUT;
                end else begin
                    div_start = 1'b1;
                    div_num   = DIV_W'(frq_num);
                    div_den   = r_elapsed;
                    n_state   = S_FRQ_WAIT;
                end
            end
            S_FRQ_WAIT: begin
                if (div_done) begin
                    n_freq  = (div_q > DIV_W'(CNT_MAX)) ? CNT_MAX : div_q[CNT_W-1:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!n_o_valid) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_dur    = (r_elapsed > TIME_W'(CNT_MAX)) ? CNT_MAX
                                                                : r_elapsed[CNT_W-1:0];
                    n_o_cross  = r_cross;
                    n_o_peak   = r_peak;
                    n_o_str    = r_str;
                    n_o_freq   = r_freq;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_o_valid;
    assign o_status          = r_o_status;
    assign o_duration_us     = r_o_dur;
    assign o_crossing_count  = r_o_cross;
    assign o_peak_deviation  = r_o_peak;
    assign o_strength_pct    = r_o_str;
    assign o_freq_tenths_khz = r_o_freq;
    assign o_cfg_ready       = 1'b1;

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_strength_pct == '0 && o_freq_tenths_khz == '0)
        else $error("rejected burst carries strength or frequency");

    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK |->
            o_strength_pct >= PCT_MIN && o_strength_pct <= PCT_FULL &&
            o_duration_us >= r_min_us && o_duration_us <= r_max_us)
        else $error("valid burst report out of range");

    a_div_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> o_in_stall)
        else $error("sample accepted while divider busy");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

endmodule

`default_nettype wire

>>> verif/ultrasonic_burst_detector_tb.sv
`timescale 1ns / 100ps

module ultrasonic_burst_detector_tb;
    import ubd_pkg::*;

    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 600;

    typedef struct {
        logic [SAMPLE_BITS-1:0] smp;
        logic [TIME_W-1:0]      ts;
    } t_sample_item;

    typedef struct {
        t_status          status;
        logic [CNT_W-1:0]  duration;
        logic [CNT_W-1:0]  crossings;
        logic [PEAK_W-1:0] peak;
        logic [PCT_W-1:0]  strength;
        logic [CNT_W-1:0]  freq;
    } t_burst_report;

    typedef struct {
        logic [BASE_W-1:0] base_lvl;
        logic [BASE_W-1:0] thresh;
        logic [15:0]       min_us;
        logic [15:0]       max_us;
        logic [BASE_W-1:0] full_dev;
    } t_detector_regs;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [SAMPLE_BITS-1:0] i_sample = '0;
    logic [TIME_W-1:0]      i_time_us = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [1:0]             o_status;
    logic [CNT_W-1:0]       o_duration_us;
    logic [CNT_W-1:0]       o_crossing_count;
    logic [PEAK_W-1:0]      o_peak_deviation;
    logic [PCT_W-1:0]       o_strength_pct;
    logic [CNT_W-1:0]       o_freq_tenths_khz;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    ultrasonic_burst_detector dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_sample          (i_sample),
        .i_time_us         (i_time_us),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_duration_us     (o_duration_us),
        .o_crossing_count  (o_crossing_count),
        .o_peak_deviation  (o_peak_deviation),
        .o_strength_pct    (o_strength_pct),
        .o_freq_tenths_khz (o_freq_tenths_khz),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Detector shadow: register copy and burst tracking state.
    t_detector_regs regs = '{RST_BASELINE, RST_THRESH, RST_MIN_US, RST_MAX_US, RST_FULL};
    bit               in_burst = 1'b0;
    logic [TIME_W-1:0] start_ts = '0;
    int unsigned      peak_dev = 0;
    int unsigned      cross_cnt = 0;
    bit               prev_above = 1'b0;

    t_sample_item     sample_queue[$];
    t_burst_report    pending_reports[$];
    t_sample_item     head;
    t_burst_report    next_report;
    t_burst_report    oldest_report;
    logic [TIME_W-1:0] stamp = '0;
    int unsigned      error_count = 0;
    int unsigned      cycle_cnt = 0;
    int unsigned      hold_left = 0;
    bit               hold_now = 1'b0;
    bit               hold_done = 1'b0;
    logic             calm;

    // Both sides run without idling in the calm part of each cycle_cnt period, save during the long hold-off.
    assign calm = (cycle_cnt % 3000) < 800;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic int unsigned burst_strength(int unsigned pk);
        int unsigned thr;
        int unsigned fs;
        int unsigned v;
        thr = regs.thresh;
        fs = regs.full_dev;
        if (fs <= thr) return PCT_FULL;
        if (pk <= thr) return PCT_MIN;
        v = (pk - thr) * PCT_SPAN / (fs - thr) + PCT_MIN;
        return (v > PCT_FULL) ? PCT_FULL : v;
    endfunction

    function automatic int unsigned burst_freq(int unsigned crossings, int unsigned elapsed);
        longint unsigned f;
        if (elapsed == 0) return 0;
        f = longint'(crossings) * FREQ_SCALE / longint'(elapsed);
        return (f > CNT_MAX) ? CNT_MAX : int'(f);
    endfunction

    // Advances the shadow detector by one sample; returns 1 when a burst report results.
    function automatic bit detector_step(input logic [SAMPLE_BITS-1:0] smp,
                                         input logic [TIME_W-1:0] ts,
                                         output t_burst_report rep);
        int unsigned s;
        int unsigned b;
        int unsigned dev;
        int unsigned elapsed;
        bit above;
        bit ended;
        s = smp;
        b = regs.base_lvl;
        above = s > b;
        dev = above ? s - b : b - s;
        rep.status = ST_OK;
        rep.duration = '0;
        rep.crossings = '0;
        rep.peak = '0;
        rep.strength = '0;
        rep.freq = '0;
        if (!in_burst) begin
            if (dev >= regs.thresh) begin
                in_burst = 1'b1;
                start_ts = ts;
                peak_dev = (dev > PEAK_MAX) ? PEAK_MAX : dev;
                cross_cnt = 0;
                prev_above = above;
            end
            return 1'b0;
        end
        if (above != prev_above && cross_cnt < CNT_MAX) cross_cnt++;
        prev_above = above;
        if (dev > PEAK_MAX) dev = PEAK_MAX;
        if (dev > peak_dev) peak_dev = dev;
        elapsed = ts - start_ts;
        ended = dev < (regs.thresh >> 1);
        if (!ended && elapsed <= regs.max_us) return 1'b0;
        if (elapsed > regs.max_us) rep.status = ST_LONG;
        else if (elapsed < regs.min_us) rep.status = ST_SHORT;
        else rep.status = ST_OK;
        rep.duration = (elapsed > CNT_MAX) ? CNT_MAX : elapsed[CNT_W-1:0];
        rep.crossings = cross_cnt[CNT_W-1:0];
        rep.peak = peak_dev[PEAK_W-1:0];
        if (rep.status == ST_OK) begin
            rep.strength = PCT_W'(burst_strength(peak_dev));
            rep.freq = CNT_W'(burst_freq(cross_cnt, elapsed));
        end
        in_burst = 1'b0;
        return 1'b1;
    endfunction

    function automatic void compare_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
            error_count++;
        end
    endfunction

    // Driver: an accepted sample goes through the shadow detector at its transfer edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (detector_step(i_sample, i_time_us, next_report))
                    pending_reports.push_back(next_report);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (sample_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
                    head = sample_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_sample <= head.smp;
                    i_time_us <= head.ts;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each report transfer and drives the output stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: report with none expected: expected nothing, actual status %0d",
                             $time, o_status);
                    error_count++;
                end else begin
                    oldest_report = pending_reports.pop_front();
                    compare_field("status", oldest_report.status, o_status);
                    compare_field("duration_us", oldest_report.duration, o_duration_us);
                    compare_field("crossing_count", oldest_report.crossings, o_crossing_count);
                    compare_field("peak_deviation", oldest_report.peak, o_peak_deviation);
                    compare_field("strength_pct", oldest_report.strength, o_strength_pct);
                    compare_field("freq_tenths_khz", oldest_report.freq, o_freq_tenths_khz);
                end
            end
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (hold_now && !hold_done) begin
                // Long hold-off so that reports back up and the block stalls its input.
                i_out_stall <= 1'b1;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(0, 99) < 25);
            end
        end
    end

    function automatic void offer(logic [SAMPLE_BITS-1:0] smp, logic [TIME_W-1:0] ts);
        t_sample_item it;
        it.smp = smp;
        it.ts = ts;
        sample_queue.push_back(it);
    endfunction

    // Sample at a given distance from the baseline, on the requested side where it fits.
    function automatic logic [SAMPLE_BITS-1:0] level_at(int unsigned mag, bit up);
        int b;
        int v;
        b = regs.base_lvl;
        if (up && b + int'(mag) > 4095) up = 1'b0;
        else if (!up && int'(mag) > b) up = 1'b1;
        v = up ? b + int'(mag) : b - int'(mag);
        if (v > 4095) v = 4095;
        if (v < 0) v = 0;
        return v[SAMPLE_BITS-1:0];
    endfunction

    // A trigger, an alternating body and a closing sample, spread over a chosen duration.
    function automatic int unsigned queue_burst();
        int unsigned half;
        int unsigned reach;
        int unsigned n;
        int unsigned dur;
        int unsigned mn;
        int unsigned mx;
        int unsigned mag;
        logic [TIME_W-1:0] t0;
        bit up;
        half = regs.thresh >> 1;
        reach = (regs.base_lvl > 4095 - regs.base_lvl) ? regs.base_lvl : 4095 - regs.base_lvl;
        mn = regs.min_us;
        mx = regs.max_us;
        if (regs.thresh > reach) return 0;
        n = $urandom_range(1, 12);
        case ($urandom_range(0, 9))
            0, 1: dur = $urandom_range(0, mn - 1);
            2, 3, 4, 5, 6: dur = (mn <= mx) ? $urandom_range(mn, mx) : $urandom_range(0, mn - 1);
            7, 8: dur = mx + $urandom_range(1, 3000);
            default: dur = $urandom;
        endcase
        t0 = stamp;
        up = 1'($urandom_range(0, 1));
        offer(level_at($urandom_range(regs.thresh, reach), up), t0);
        for (int k = 1; k <= n; k++) begin
            if ($urandom_range(0, 99) < 85) up = !up;
            offer(level_at($urandom_range(half, reach), up),
                  t0 + 32'((64'(dur) * k) / (n + 1)));
        end
        // With a threshold below 2 nothing ends by level, so the burst only times out.
        mag = (half > 0) ? $urandom_range(0, half - 1) : $urandom_range(half, reach);
        offer(level_at(mag, 1'($urandom_range(0, 1))), t0 + dur);
        stamp = t0 + dur + $urandom_range(1, 400);
        return n + 2;
    endfunction

    function automatic int unsigned queue_noise();
        case ($urandom_range(0, 5))
            0: stamp = $urandom;
            1: stamp = 32'hFFFF_FFFF - $urandom_range(0, 2000);
            default: stamp = stamp + $urandom_range(0, 50);
        endcase
        offer(SAMPLE_BITS'($urandom_range(0, 4095)), stamp);
        return 1;
    endfunction

    function automatic int unsigned queue_quiet(int unsigned count);
        int unsigned made;
        made = 0;
        for (int k = 0; k < count; k++) begin
            if (regs.thresh != 0) begin
                offer(level_at($urandom_range(0, regs.thresh - 1), 1'($urandom_range(0, 1))),
                      stamp);
                made++;
            end
            stamp = stamp + $urandom_range(1, 100);
        end
        return made;
    endfunction

    function automatic void fill_phase(int unsigned target);
        int unsigned made;
        made = 0;
        while (made < target) begin
            if ($urandom_range(0, 99) < 12) made += queue_noise();
            else made += queue_burst();
            made += queue_quiet($urandom_range(0, 3));
        end
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BASELINE: regs.base_lvl = val[BASE_W-1:0];
            CFG_THRESH:   regs.thresh = val[BASE_W-1:0];
            CFG_MIN_US:   regs.min_us = val;
            CFG_MAX_US:   regs.max_us = val;
            CFG_FULL:     regs.full_dev = val[BASE_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_detector(logic [15:0] b, logic [15:0] th, logic [15:0] mn,
                                    logic [15:0] mx, logic [15:0] fs);
        write_reg(CFG_BASELINE, b);
        write_reg(CFG_THRESH, th);
        write_reg(CFG_MIN_US, mn);
        write_reg(CFG_MAX_US, mx);
        write_reg(CFG_FULL, fs);
    endtask

    // The sender pauses here until every expected report has been taken.
    task automatic wait_drained();
        while (sample_queue.size() != 0 || i_in_valid || pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: baseline 2048, threshold 120, window 500..5000 us.
        offer(12'd2048, 32'hFFFF_FFFF);
        offer(12'd2048, 32'd0);
        offer(12'd2168, 32'd1000);
        offer(12'd1848, 32'd1100);
        offer(12'd4095, 32'd1300);
        offer(12'd2107, 32'd1700);
        offer(12'd0, 32'd2000);
        offer(12'd2048, 32'd2100);
        // Burst that straddles the timestamp wrap and ends past the maximum.
        offer(12'd1928, 32'hFFFF_FF00);
        offer(12'd2200, 32'h0000_1000);
        offer(12'd2048, 32'h0000_1400);
        // Abort while the signal is still strong.
        offer(12'd3000, 32'd10000);
        offer(12'd3000, 32'd15001);
        offer(12'd2500, 32'd20000);
        offer(12'd2048, 32'd20000);
        offer(12'd2600, 32'd30000);
        offer(12'd1500, 32'd30200);
        offer(12'd2048, 32'd30500);
        offer(12'd2600, 32'd40000);
        offer(12'd2109, 32'd45000);
        offer(12'd2048, 32'd45000);
        // Peak exactly at the threshold gives the lowest strength.
        offer(12'd2168, 32'd50000);
        offer(12'd2048, 32'd50600);
        stamp = 32'd60000;
        fill_phase(90);
        wait_drained();

        for (int phase = 1; phase <= 7; phase++) begin
            case (phase)
                1: program_detector(16'd2048, 16'd1, 16'd1, 16'd3000, 16'd4095);
                2: program_detector(16'd0, 16'd4095, 16'd65535, 16'd1, 16'd2);
                3: program_detector(16'd4095, 16'd600, 16'd200, 16'd65535, 16'd1500);
                4: program_detector(16'd1000, 16'd0, 16'd100, 16'd2000, 16'd900);
                default: program_detector(16'($urandom_range(0, 4095)),
                                          16'($urandom_range(1, 1500)),
                                          16'($urandom_range(1, 3000)),
                                          16'($urandom_range(1, 20000)),
                                          16'($urandom_range(2, 4095)));
            endcase
            @(negedge i_clk);
            fill_phase(85);
            if (phase == 1) hold_now = 1'b1;
            wait_drained();
        end

        if (error_count == 0)
            $display("ultrasonic_burst_detector_tb: done, clean");
        else
            $display("ultrasonic_burst_detector_tb: done, errors");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("ultrasonic_burst_detector_tb: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
rtl/ubd_pkg.sv
rtl/ubd_div.sv
rtl/ultrasonic_burst_detector.sv
verif/ultrasonic_burst_detector_tb.sv
